@@ rtl/egs_pkg.sv @@
// Package for the signing engine: payload structs, state encoding, constants.
// No dependencies.
package egs_pkg;
  localparam int MODULUS_BITS_DEF = 63;
  localparam int W = 63;

  typedef struct packed {
    logic [W-1:0] nonce;
    logic [W-1:0] message;
  } egs_in_t;

  typedef struct packed {
    logic [W-1:0] gamma;
    logic [W-1:0] sigma;
    logic         status;
  } egs_out_t;

  typedef enum logic [1:0] {
    CFG_MODULUS     = 2'd0,
    CFG_GENERATOR   = 2'd1,
    CFG_PRIVATE_KEY = 2'd2
  } egs_cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_KRED, S_EU_INIT, S_EU_DIV, S_EU_MUL, S_EU_STEP, S_EU_END,
    S_GRED, S_PW_TEST, S_PW_MUL, S_PW_SQ, S_XRED, S_ARED, S_GMRED, S_AG,
    S_DIFF, S_SIG, S_DONE
  } egs_state_t;

  typedef enum logic [1:0] {
    MO_RED, MO_MUL, MO_DIV
  } egs_op_t;
endpackage

@@ rtl/egs_arith.sv @@
// Bit-serial arithmetic unit: modular multiply (shift-and-add, one bit per
// cycle), reduction and restoring division (one quotient bit per cycle).
// Depends on egs_pkg.
module egs_arith #(
  parameter int N = egs_pkg::MODULUS_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  egs_pkg::egs_op_t    op,
  input  logic [N-1:0]        a,
  input  logic [N-1:0]        b,
  input  logic [N-1:0]        m,
  output logic                done,
  output logic [N-1:0]        res,
  output logic [N-1:0]        rem
);
  import egs_pkg::*;

  localparam int CW = $clog2(N + 1);

  logic             busy_r, busy_nxt;
  egs_op_t          op_r, op_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [N-1:0]     x_r, x_nxt, y_r, y_nxt, acc_r, acc_nxt, m_r, m_nxt;
  logic             done_r, done_nxt;
  logic [N:0]       s1, s2, sh;

  always_comb begin
    busy_nxt = busy_r;
    op_nxt = op_r;
    cnt_nxt = cnt_r;
    x_nxt = x_r;
    y_nxt = y_r;
    acc_nxt = acc_r;
    m_nxt = m_r;
    done_nxt = 1'b0;
    s1 = '0;
    s2 = '0;
    sh = '0;
    if (go) begin
      busy_nxt = 1'b1;
      op_nxt = op;
      m_nxt = m;
      cnt_nxt = CW'(N);
      unique case (op)
        MO_MUL: begin
          x_nxt = a;
          y_nxt = b;
          acc_nxt = '0;
        end
        default: begin
          x_nxt = a;
          y_nxt = '0;
          acc_nxt = '0;
        end
      endcase
    end else if (busy_r) begin
      unique case (op_r)
        MO_MUL: begin
          s1 = {1'b0, acc_r} + {1'b0, x_r};
          if (y_r[0]) acc_nxt = (s1 >= {1'b0, m_r}) ? N'(s1 - {1'b0, m_r}) : N'(s1);
          s2 = {x_r, 1'b0};
          x_nxt = (s2 >= {1'b0, m_r}) ? N'(s2 - {1'b0, m_r}) : N'(s2);
          y_nxt = y_r >> 1;
        end
        default: begin
          sh = {acc_r, x_r[N-1]};
          x_nxt = x_r << 1;
          if (sh >= {1'b0, m_r}) begin
            acc_nxt = N'(sh - {1'b0, m_r});
            x_nxt[0] = 1'b1;
          end else begin
            acc_nxt = N'(sh);
          end
        end
      endcase
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r <= MO_RED;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r <= op_nxt;
      cnt_r <= cnt_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    acc_r <= acc_nxt;
    m_r <= m_nxt;
  end

  assign done = done_r;
  assign res = (op_r == MO_DIV) ? x_r : acc_r;
  assign rem = acc_r;
endmodule

@@ rtl/elgamal_signature_sign.sv @@
// Top level of the ElGamal signing engine: sequencer, configuration, results.
// Depends on egs_pkg and egs_arith.
// The time for one signature is set by the bit-serial unit, which carries out
// every modular multiply, reduction and division. gamma needs up to
// 2*MODULUS_BITS multiplies. Each Euclid round needs two operations, over at
// most about 1.44*MODULUS_BITS rounds, and seven further operations are
// needed besides. busy stays high for the whole transaction. Configuration
// writes are held off while busy.
// The result shows on out_valid for one cycle and cannot be held off.
module elgamal_signature_sign #(
  parameter int MODULUS_BITS = egs_pkg::MODULUS_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  egs_pkg::egs_in_t   in_data,
  output logic               out_valid,
  output egs_pkg::egs_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [egs_pkg::W-1:0] cfg_data
);
  import egs_pkg::*;

  localparam int N = MODULUS_BITS;

  egs_state_t  st_r, st_nxt;
  logic [N-1:0] p_r, g_r, a_r;
  logic [N-1:0] k_r, x_r, m1_r, km_r;
  logic [N-1:0] r0_r, r1_r, t0_r, t1_r, rr_r;
  logic [N-1:0] res_r, sq_r, e_r, gam_r, tmp_r;
  logic         bad_r;
  logic [N-1:0] k_nxt, x_nxt, m1_nxt, km_nxt, r0_nxt, r1_nxt, t0_nxt, t1_nxt;
  logic [N-1:0] rr_nxt, res_nxt, sq_nxt, e_nxt, gam_nxt, tmp_nxt;
  logic         bad_nxt;
  logic         ov_r, ov_nxt;
  egs_out_t     od_r, od_nxt;

  logic        ar_go, ar_done;
  egs_op_t     ar_op;
  logic [N-1:0] ar_a, ar_b, ar_m, ar_res, ar_rem;

  egs_arith #(.N(N)) u_arith (
    .clk, .rst_n, .go(ar_go), .op(ar_op), .a(ar_a), .b(ar_b), .m(ar_m),
    .done(ar_done), .res(ar_res), .rem(ar_rem)
  );

  assign cfg_ready = (st_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= N'(11);
      g_r <= N'(2);
      a_r <= N'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODULUS:     p_r <= cfg_data[N-1:0];
        CFG_GENERATOR:   g_r <= cfg_data[N-1:0];
        CFG_PRIVATE_KEY: a_r <= cfg_data[N-1:0];
        default: ;
      endcase
    end
  end

  logic [N-1:0] sub_tmp;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:    if (start) st_nxt = (p_r < N'(3)) ? S_DONE : S_KRED;
      S_KRED:    if (ar_done) st_nxt = S_EU_INIT;
      S_EU_INIT: st_nxt = S_EU_STEP;
      S_EU_STEP: st_nxt = (r1_r == '0) ? S_EU_END : S_EU_DIV;
      S_EU_DIV:  if (ar_done) st_nxt = S_EU_MUL;
      S_EU_MUL:  if (ar_done) st_nxt = S_EU_STEP;
      S_EU_END:  st_nxt = (r0_r != N'(1)) ? S_DONE : S_GRED;
      S_GRED:    if (ar_done) st_nxt = S_PW_TEST;
      S_PW_TEST: st_nxt = (e_r == '0) ? S_XRED : (e_r[0] ? S_PW_MUL : S_PW_SQ);
      S_PW_MUL:  if (ar_done) st_nxt = S_PW_SQ;
      S_PW_SQ:   if (ar_done) st_nxt = S_PW_TEST;
      S_XRED:    if (ar_done) st_nxt = S_ARED;
      S_ARED:    if (ar_done) st_nxt = S_GMRED;
      S_GMRED:   if (ar_done) st_nxt = S_AG;
      S_AG:      if (ar_done) st_nxt = S_DIFF;
      S_DIFF:    st_nxt = S_SIG;
      S_SIG:     if (ar_done) st_nxt = S_DONE;
      S_DONE:    st_nxt = S_IDLE;
      default:   st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ar_go = 1'b0;
    ar_op = MO_RED;
    ar_a = '0;
    ar_b = '0;
    ar_m = m1_r;
    k_nxt = k_r; x_nxt = x_r; m1_nxt = m1_r; km_nxt = km_r;
    r0_nxt = r0_r; r1_nxt = r1_r; t0_nxt = t0_r; t1_nxt = t1_r;
    rr_nxt = rr_r; res_nxt = res_r; sq_nxt = sq_r;
    e_nxt = e_r; gam_nxt = gam_r; tmp_nxt = tmp_r; bad_nxt = bad_r;
    ov_nxt = 1'b0;
    od_nxt = od_r;
    sub_tmp = '0;
    unique case (st_r)
      S_IDLE: if (start) begin
        k_nxt = in_data.nonce[N-1:0];
        x_nxt = in_data.message[N-1:0];
        m1_nxt = p_r - 1'b1;
        bad_nxt = 1'b1;
        if (p_r >= N'(3)) begin
          ar_go = 1'b1; ar_op = MO_RED; ar_a = in_data.nonce[N-1:0];
          ar_m = p_r - 1'b1;
        end
      end
      S_KRED: if (ar_done) km_nxt = ar_rem;
      S_EU_INIT: begin
        r0_nxt = m1_r; r1_nxt = km_r; t0_nxt = '0;
        t1_nxt = (m1_r == N'(1)) ? '0 : N'(1);
      end
      S_EU_STEP: if (r1_r != '0) begin
        ar_go = 1'b1; ar_op = MO_DIV; ar_a = r0_r; ar_m = r1_r;
      end
      S_EU_DIV: if (ar_done) begin
        rr_nxt = ar_rem;
        ar_go = 1'b1; ar_op = MO_MUL; ar_a = t1_r; ar_b = ar_res;
      end
      S_EU_MUL: if (ar_done) begin
        sub_tmp = (t0_r >= ar_res) ? t0_r - ar_res : t0_r + (m1_r - ar_res);
        r0_nxt = r1_r; r1_nxt = rr_r; t0_nxt = t1_r; t1_nxt = sub_tmp;
      end
      S_EU_END: if (r0_r == N'(1)) begin
        ar_go = 1'b1; ar_op = MO_RED; ar_a = g_r; ar_m = p_r;
        res_nxt = N'(1); e_nxt = k_r;
      end
      S_GRED: if (ar_done) sq_nxt = ar_rem;
      S_PW_TEST: begin
        ar_m = p_r;
        if (e_r == '0) begin
          gam_nxt = res_r;
          ar_go = 1'b1; ar_op = MO_RED; ar_a = x_r; ar_m = m1_r;
        end else if (e_r[0]) begin
          ar_go = 1'b1; ar_op = MO_MUL; ar_a = res_r; ar_b = sq_r;
        end else begin
          ar_go = 1'b1; ar_op = MO_MUL; ar_a = sq_r; ar_b = sq_r;
        end
      end
      S_PW_MUL: begin
        ar_m = p_r;
        if (ar_done) begin
          res_nxt = ar_res;
          ar_go = 1'b1; ar_op = MO_MUL; ar_a = sq_r; ar_b = sq_r;
        end
      end
      S_PW_SQ: if (ar_done) begin
        sq_nxt = ar_res; e_nxt = e_r >> 1;
      end
      S_XRED: if (ar_done) begin
        x_nxt = ar_rem;
        ar_go = 1'b1; ar_op = MO_RED; ar_a = a_r;
      end
      S_ARED: if (ar_done) begin
        tmp_nxt = ar_rem;
        ar_go = 1'b1; ar_op = MO_RED; ar_a = gam_r;
      end
      S_GMRED: if (ar_done) begin
        ar_go = 1'b1; ar_op = MO_MUL; ar_a = tmp_r; ar_b = ar_rem;
      end
      S_AG: if (ar_done) tmp_nxt = ar_res;
      S_DIFF: begin
        sub_tmp = (x_r >= tmp_r) ? x_r - tmp_r : x_r + (m1_r - tmp_r);
        ar_go = 1'b1; ar_op = MO_MUL; ar_a = t0_r; ar_b = sub_tmp;
      end
      S_SIG: if (ar_done) begin
        tmp_nxt = ar_res; bad_nxt = 1'b0;
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        od_nxt = '0;
        od_nxt.status = bad_r;
        if (!bad_r) begin
          od_nxt.gamma = W'(gam_r);
          od_nxt.sigma = W'(tmp_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    k_r <= k_nxt; x_r <= x_nxt; m1_r <= m1_nxt; km_r <= km_nxt;
    r0_r <= r0_nxt; r1_r <= r1_nxt; t0_r <= t0_nxt; t1_r <= t1_nxt;
    rr_r <= rr_nxt; res_r <= res_nxt; sq_r <= sq_nxt;
    e_r <= e_nxt; gam_r <= gam_nxt; tmp_r <= tmp_nxt; bad_r <= bad_nxt;
    od_r <= od_nxt;
  end

  assign busy = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data = od_r;
endmodule
